[src/imu_ctf_pkg.sv]
package imu_ctf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_TABLE_SIZE  = 24;
	localparam int SQRT_STEPS       = 17;
	localparam int DIV_STEPS        = 41;

	localparam logic signed [16:0] ANGLE_LIMIT = 17'sd46080;
	localparam logic [26:0] GYRO_DIVISOR = 27'd131000000;
	localparam logic [40:0] GYRO_HALF    = 41'd65500000;
	localparam logic signed [25:0] QUARTER_TURN = 26'sd5898240;

	localparam logic [2:0] REG_GYRO_BIAS_X  = 3'd0;
	localparam logic [2:0] REG_GYRO_BIAS_Y  = 3'd1;
	localparam logic [2:0] REG_ACCEL_BIAS_X = 3'd2;
	localparam logic [2:0] REG_ACCEL_BIAS_Y = 3'd3;
	localparam logic [2:0] REG_ACCEL_BIAS_Z = 3'd4;
	localparam logic [2:0] REG_TIME_STEP    = 3'd5;
	localparam logic [2:0] REG_BLEND_WEIGHT = 3'd6;

	localparam logic [15:0] TIME_STEP_RST    = 16'd1000;
	localparam logic [15:0] BLEND_WEIGHT_RST = 16'd62915;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_ITER,
		ST_BLEND1,
		ST_BLEND2,
		ST_DONE
	} ctf_state_t;

	// atan(2^-i) in 1/65536 degree, rounded to nearest.
	function automatic logic [22:0] atan_entry(input logic [4:0] idx);
		logic [22:0] r;
		case (idx)
			5'd0:  r = 23'd2949120;
			5'd1:  r = 23'd1740967;
			5'd2:  r = 23'd919879;
			5'd3:  r = 23'd466945;
			5'd4:  r = 23'd234379;
			5'd5:  r = 23'd117304;
			5'd6:  r = 23'd58666;
			5'd7:  r = 23'd29335;
			5'd8:  r = 23'd14668;
			5'd9:  r = 23'd7334;
			5'd10: r = 23'd3667;
			5'd11: r = 23'd1833;
			5'd12: r = 23'd917;
			5'd13: r = 23'd458;
			5'd14: r = 23'd229;
			5'd15: r = 23'd115;
			5'd16: r = 23'd57;
			5'd17: r = 23'd29;
			5'd18: r = 23'd14;
			5'd19: r = 23'd7;
			5'd20: r = 23'd4;
			5'd21: r = 23'd2;
			5'd22: r = 23'd1;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

	// Saturates a wide angle to +-180 degrees in 1/256 degree.
	function automatic logic signed [16:0] sat_angle(input logic signed [19:0] v);
		logic signed [16:0] r;
		if (v > 20'(ANGLE_LIMIT))
			r = ANGLE_LIMIT;
		else if (v < -20'(ANGLE_LIMIT))
			r = -ANGLE_LIMIT;
		else
			r = v[16:0];
		return r;
	endfunction

endpackage

[src/imu_complementary_tilt_filter.sv]
// Complementary pitch/roll filter for a six-axis inertial sensor.
//
// Input channel: one beat carries a raw sample (accel_x/y/z, gyro_x/y). The
// beat is taken when in_valid is high and in_stall is low. Output channel:
// one beat per sample carries the fused pitch_angle and roll_angle in 1/256
// degree, saturated at +-180 degrees; it is taken when out_valid is high and
// out_stall is low.
// CORDIC_STEPS is capped at 24. One sample is worked on at a time:
// in_stall is low only while the block is idle, so a new sample is taken
// only once the previous result has been handed to the output register.
// The bit-serial gyro divider runs alongside the bit-pair square root and
// the shared-iteration CORDIC that follows it; the iteration phase lasts
// as long as the longer of the two.
// A finished result sits in the output register, and the next sample is
// taken while it waits. If the receiver still stalls when the following
// result is ready, that result is held until the register frees up.
// Reset clears both estimates to zero and restores the register defaults
// (time step 1000 us, blend weight 62915). Configuration is written through
// cfg_write/cfg_index/cfg_data; indexes beyond the list are ignored.
module imu_complementary_tilt_filter
	import imu_ctf_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_y,
	input  logic signed [15:0]  accel_z,
	input  logic signed [15:0]  gyro_x,
	input  logic signed [15:0]  gyro_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [16:0]  pitch_angle,
	output logic signed [16:0]  roll_angle
);

	localparam int STEPS     = (CORDIC_STEPS > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE : CORDIC_STEPS;
	localparam int ITER_LAST = (SQRT_STEPS + STEPS > DIV_STEPS - 1) ?
		SQRT_STEPS + STEPS : DIV_STEPS - 1;
	localparam int CNT_W     = $clog2(ITER_LAST + 1);

	// Configuration registers.
	logic signed [15:0] gyro_bias_x_q, gyro_bias_y_q;
	logic signed [15:0] accel_bias_x_q, accel_bias_y_q, accel_bias_z_q;
	logic [15:0]        time_step_q, blend_weight_q;

	ctf_state_t state_q, state_d;

	// Lane 0 is pitch, lane 1 is roll throughout.
	logic signed [16:0] est_q [2];
	logic signed [16:0] ax_q, ay_q, az_q;
	logic signed [16:0] g_q [2];
	logic signed [33:0] sqa_q, sqb_q;
	logic [32:0]        gmag_q [2];
	logic               gneg_q [2];

	// Bit-serial divider, one quotient bit per cycle.
	logic [40:0] dvd_q [2];
	logic [26:0] drem_q [2];
	logic [27:0] dshift [2];
	logic        dge [2];

	// Bit-pair square root.
	logic [33:0] ssrc_q;
	logic [17:0] srem_q;
	logic [16:0] root_q;
	logic [19:0] s_r4, s_trial;

	// CORDIC lanes.
	logic signed [39:0] cx_q [2], cy_q [2];
	logic signed [25:0] cz_q [2];
	logic               czero_q [2];
	logic signed [17:0] lx [2], ly [2], px [2], py [2];
	logic signed [25:0] pz [2];
	logic signed [39:0] cdx [2], cdy [2];
	logic signed [25:0] cat;
	logic [CNT_W-1:0]   kdiff;
	logic [4:0]         kidx;

	logic [CNT_W-1:0] cnt_q;

	// Blend path.
	logic signed [25:0] zround [2];
	logic signed [16:0] acc_ang [2], gyr_ang [2];
	logic signed [18:0] ginc [2];
	logic signed [35:0] pa_q [2], pb_q [2];
	logic signed [17:0] wa, wb;
	logic signed [36:0] bsum [2];

	logic signed [16:0] pitch_q, roll_q;
	logic               out_valid_q;

	logic accept_in, do_sqrt, do_load, do_cordic, do_div, iter_end, out_free;

	// ---------------------------------------------------------------
	// Next state and control.
	// ---------------------------------------------------------------
	assign accept_in = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign iter_end  = (cnt_q == CNT_W'(ITER_LAST));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_MUL;
			ST_MUL:    state_d = ST_SUM;
			ST_SUM:    state_d = ST_ITER;
			ST_ITER:   if (iter_end) state_d = ST_BLEND1;
			ST_BLEND1: state_d = ST_BLEND2;
			ST_BLEND2: state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		do_sqrt   = 1'b0;
		do_load   = 1'b0;
		do_cordic = 1'b0;
		do_div    = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_ITER: begin
				do_sqrt   = cnt_q < CNT_W'(SQRT_STEPS);
				do_load   = cnt_q == CNT_W'(SQRT_STEPS);
				do_cordic = (cnt_q > CNT_W'(SQRT_STEPS)) &&
					(cnt_q <= CNT_W'(SQRT_STEPS + STEPS));
				do_div    = cnt_q < CNT_W'(DIV_STEPS);
			end
			default: in_stall = 1'b1;
		endcase
	end

	// ---------------------------------------------------------------
	// Datapath step logic.
	// ---------------------------------------------------------------
	assign s_r4    = {srem_q, ssrc_q[33:32]};
	assign s_trial = {1'b0, root_q, 2'b01};

	assign kdiff = cnt_q - CNT_W'(SQRT_STEPS + 1);
	assign kidx  = kdiff[4:0];
	assign cat   = 26'(signed'({1'b0, atan_entry(kidx)}));

	assign wa = 18'(signed'({1'b0, blend_weight_q}));
	assign wb = 18'sd65536 - wa;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			dshift[l] = {drem_q[l], dvd_q[l][40]};
			dge[l]    = dshift[l] >= {1'b0, GYRO_DIVISOR};
		end

		// Operands for the two vectoring runs.
		lx[0] = {1'b0, root_q};
		ly[0] = -18'(ax_q);
		lx[1] = 18'(az_q);
		ly[1] = 18'(ay_q);
		for (int l = 0; l < 2; l++) begin
			// Left half plane: rotate by a quarter turn first.
			if (lx[l] < 0) begin
				if (ly[l] >= 0) begin
					px[l] = ly[l];
					py[l] = -lx[l];
					pz[l] = QUARTER_TURN;
				end else begin
					px[l] = -ly[l];
					py[l] = lx[l];
					pz[l] = -QUARTER_TURN;
				end
			end else begin
				px[l] = lx[l];
				py[l] = ly[l];
				pz[l] = '0;
			end
			cdx[l] = cy_q[l] >>> kidx;
			cdy[l] = cx_q[l] >>> kidx;

			zround[l]  = (cz_q[l] + 26'sd128) >>> 8;
			acc_ang[l] = czero_q[l] ? 17'sd0 : sat_angle(20'(zround[l]));
			ginc[l]    = gneg_q[l] ? -19'(signed'({1'b0, dvd_q[l][14:0]})) :
				19'(signed'({1'b0, dvd_q[l][14:0]}));
			gyr_ang[l] = sat_angle(20'(19'(est_q[l]) + ginc[l]));
			bsum[l]    = 37'(pa_q[l]) + 37'(pb_q[l]) + 37'sd32768;
		end
	end

	// ---------------------------------------------------------------
	// Registers.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			gyro_bias_x_q  <= '0;
			gyro_bias_y_q  <= '0;
			accel_bias_x_q <= '0;
			accel_bias_y_q <= '0;
			accel_bias_z_q <= '0;
			time_step_q    <= TIME_STEP_RST;
			blend_weight_q <= BLEND_WEIGHT_RST;
			est_q[0]       <= '0;
			est_q[1]       <= '0;
			out_valid_q    <= 1'b0;
			cnt_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_GYRO_BIAS_X:  gyro_bias_x_q  <= cfg_data;
					REG_GYRO_BIAS_Y:  gyro_bias_y_q  <= cfg_data;
					REG_ACCEL_BIAS_X: accel_bias_x_q <= cfg_data;
					REG_ACCEL_BIAS_Y: accel_bias_y_q <= cfg_data;
					REG_ACCEL_BIAS_Z: accel_bias_z_q <= cfg_data;
					REG_TIME_STEP:    time_step_q    <= cfg_data;
					REG_BLEND_WEIGHT: blend_weight_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_SUM)
				cnt_q <= '0;
			else if (state_q == ST_ITER && !iter_end)
				cnt_q <= cnt_q + 1'b1;
			if (state_q == ST_BLEND2) begin
				est_q[0] <= sat_angle(bsum[0][35:16]);
				est_q[1] <= sat_angle(bsum[1][35:16]);
			end
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			ax_q   <= 17'(accel_x) - 17'(accel_bias_x_q);
			ay_q   <= 17'(accel_y) - 17'(accel_bias_y_q);
			az_q   <= 17'(accel_z) - 17'(accel_bias_z_q);
			g_q[0] <= 17'(gyro_x) - 17'(gyro_bias_x_q);
			g_q[1] <= 17'(gyro_y) - 17'(gyro_bias_y_q);
		end
		if (state_q == ST_MUL) begin
			sqa_q <= ay_q * ay_q;
			sqb_q <= az_q * az_q;
			for (int l = 0; l < 2; l++) begin
				gneg_q[l] <= g_q[l][16];
				gmag_q[l] <= (g_q[l][16] ? 17'(-g_q[l]) : 17'(g_q[l])) * time_step_q;
			end
		end
		if (state_q == ST_SUM) begin
			ssrc_q <= 34'(sqa_q + sqb_q);
			srem_q <= '0;
			root_q <= '0;
			for (int l = 0; l < 2; l++) begin
				dvd_q[l]  <= {gmag_q[l], 8'd0} + GYRO_HALF;
				drem_q[l] <= '0;
			end
		end
		if (do_sqrt) begin
			ssrc_q <= {ssrc_q[31:0], 2'b00};
			if (s_r4 >= s_trial) begin
				srem_q <= 18'(s_r4 - s_trial);
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				srem_q <= s_r4[17:0];
				root_q <= {root_q[15:0], 1'b0};
			end
		end
		for (int l = 0; l < 2; l++) begin
			if (do_div) begin
				drem_q[l] <= dge[l] ? 27'(dshift[l] - {1'b0, GYRO_DIVISOR}) : dshift[l][26:0];
				dvd_q[l]  <= {dvd_q[l][39:0], dge[l]};
			end
			if (do_load) begin
				cx_q[l]    <= {{2{px[l][17]}}, px[l], 20'd0};
				cy_q[l]    <= {{2{py[l][17]}}, py[l], 20'd0};
				cz_q[l]    <= pz[l];
				czero_q[l] <= (lx[l] == 18'sd0) && (ly[l] == 18'sd0);
			end
			if (do_cordic) begin
				if (cy_q[l] < 0) begin
					cx_q[l] <= cx_q[l] - cdx[l];
					cy_q[l] <= cy_q[l] + cdy[l];
					cz_q[l] <= cz_q[l] - cat;
				end else begin
					cx_q[l] <= cx_q[l] + cdx[l];
					cy_q[l] <= cy_q[l] - cdy[l];
					cz_q[l] <= cz_q[l] + cat;
				end
			end
			if (state_q == ST_BLEND1) begin
				pa_q[l] <= wa * 18'(gyr_ang[l]);
				pb_q[l] <= wb * 18'(acc_ang[l]);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			pitch_q <= est_q[0];
			roll_q  <= est_q[1];
		end
	end

	assign out_valid   = out_valid_q;
	assign pitch_angle = pitch_q;
	assign roll_angle  = roll_q;

	// ---------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------
	a_est_range: assert property (@(posedge clk) disable iff (!arst_n)
		(est_q[0] <= ANGLE_LIMIT) && (est_q[0] >= -ANGLE_LIMIT) &&
		(est_q[1] <= ANGLE_LIMIT) && (est_q[1] >= -ANGLE_LIMIT))
		else $error("estimate outside +-180 degrees");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> state_q == ST_MUL)
		else $error("accepted sample did not start work");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ITER_LAST))
		else $error("iteration counter overran");

	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (pitch_q == est_q[0]) && (roll_q == est_q[1]))
		else $error("result beat differs from new estimate");

endmodule
